### sv/tbba_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tbba_pkg
// Shared types and constants of the two-bit-tag bitmap block allocator.
// -----------------------------------------------------------------------------
package tbba_pkg;

  localparam int unsigned NBLK          = 1024;
  localparam int unsigned IDXW          = $clog2(NBLK);
  localparam int unsigned CNTW          = IDXW + 1;
  localparam int unsigned TAGS_PER_BYTE = 4;
  localparam int unsigned TPB_SHIFT     = $clog2(TAGS_PER_BYTE);

  localparam logic [1:0] TAG_FREE = 2'b00;
  localparam logic [1:0] TAG_ONE  = 2'b01;
  localparam logic [1:0] TAG_TWO  = 2'b10;
  localparam logic [1:0] TAG_MAX  = 2'b11;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_SIZE  = 2'd3
  } cmd_e;

  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_BYTES = 2'd1;
  localparam logic [1:0] CFG_BLOCK = 2'd2;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_DIV, OP_SWEEP, OP_IFIN, OP_UMUL, OP_ASTART, OP_AADDR,
    OP_ADV1, OP_WSTART, OP_WSTEP, OP_ADVW, OP_LEFT, OP_RIGHT, OP_WRID, OP_AFIN,
    OP_FID, OP_INC, OP_DEC, OP_CLRI, OP_FFIN, OP_SID, OP_SINC, OP_SMUL, OP_SFIN,
    OP_PUSH
  } dp_op_e;

  typedef enum logic [2:0] {
    DS_NB, DS_META, DS_BSM, DS_RB, DS_M32, DS_R0, DS_OFF
  } div_sel_e;

  typedef enum logic [1:0] {
    RS_P, RS_PM1, RS_Q, RS_I
  } rd_sel_e;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_NB, S_NBW, S_MDIV, S_MDIVW, S_ISW, S_IFIN,
    S_AMUL, S_APRE, S_BSMW, S_RB, S_RBW, S_M32, S_M32W, S_ASTART, S_AADDR,
    S_R0, S_R0W, S_CHK, S_WRD, S_WUSE, S_LRD, S_LUSE, S_RRD, S_RUSE, S_AWR,
    S_AFIN, S_RGN, S_ODIVW, S_FRD, S_FID, S_FBR, S_FBU, S_FFR, S_FFU, S_FFIN,
    S_SRD, S_SID, S_SCR, S_SCU, S_SMUL, S_SFIN, S_DONE
  } state_e;

  typedef struct packed {
    dp_op_e   op;
    div_sel_e dsel;
    rd_sel_e  rsel;
  } tbba_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic div_done;
    logic pre_fail;
    logic scan_ok;
    logic askip;
    logic found;
    logic q_in;
    logic i_in;
    logic i_zero;
    logic idx_in;
    logic in_rgn;
    logic tag_zero;
    logic tag_eq;
    logic wr_done;
    logic sweep_last;
    logic out_free;
  } tbba_sts_t;

endpackage
`default_nettype wire

### sv/tbba_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tbba_if
// Handshake channels of the allocator: request, response and register write.
// -----------------------------------------------------------------------------
interface tbba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] request_bytes;
  logic [16:0] align_bytes;
  logic [31:0] address;
  modport source (output valid, command, request_bytes, align_bytes, address,
                  input ready);
  modport sink   (input valid, command, request_bytes, align_bytes, address,
                  output ready);
endinterface

interface tbba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [31:0] result_bytes;
  logic        ok;
  logic [10:0] used_count;
  modport source (output valid, result_address, result_bytes, ok, used_count,
                  input ready);
  modport sink   (input valid, result_address, result_bytes, ok, used_count,
                  output ready);
endinterface

interface tbba_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/tbba_div.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tbba_div
// Restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module tbba_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [16:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [31:0]      quot_o,
  output logic [16:0]      rem_o
);
  localparam int unsigned DW = 32;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [31:0]   quo_q, quo_d;
  logic [16:0]   rem_q, rem_d, dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [17:0]   trial, diff;
  logic          ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], ge};
      rem_d = ge ? diff[16:0] : trial[16:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

### sv/tbba_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tbba_ctrl
// Command sequencer: walks init, allocate, free and size through the datapath.
// -----------------------------------------------------------------------------
module tbba_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire tbba_pkg::tbba_sts_t sts_i,
  output tbba_pkg::tbba_cmd_t      cmd_o
);
  import tbba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.sweep_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_NB;
      S_NB:    state_d = S_NBW;
      S_NBW: begin
        if (sts_i.div_done) begin
          case (sts_i.cmd)
            CMD_INIT:  state_d = S_MDIV;
            CMD_ALLOC: state_d = S_AMUL;
            default:   state_d = S_RGN;
          endcase
        end
      end
      S_MDIV:  state_d = S_MDIVW;
      S_MDIVW: if (sts_i.div_done) state_d = S_ISW;
      S_ISW:   if (sts_i.sweep_last) state_d = S_IFIN;
      S_IFIN:  state_d = S_DONE;
      S_AMUL:  state_d = S_APRE;
      S_APRE:  state_d = sts_i.pre_fail ? S_DONE : S_BSMW;
      S_BSMW:  if (sts_i.div_done) state_d = S_RB;
      S_RB:    state_d = S_RBW;
      S_RBW:   if (sts_i.div_done) state_d = S_M32;
      S_M32:   state_d = S_M32W;
      S_M32W:  if (sts_i.div_done) state_d = S_ASTART;
      S_ASTART: state_d = S_AADDR;
      S_AADDR: state_d = S_R0;
      S_R0:    state_d = S_R0W;
      S_R0W:   if (sts_i.div_done) state_d = S_CHK;
      S_CHK: begin
        if (!sts_i.scan_ok) state_d = S_DONE;
        else if (!sts_i.askip) state_d = S_WRD;
      end
      S_WRD: begin
        if (sts_i.found) state_d = S_LRD;
        else if (!sts_i.q_in) state_d = S_CHK;
        else state_d = S_WUSE;
      end
      S_WUSE:  state_d = sts_i.tag_zero ? S_WRD : S_CHK;
      S_LRD:   state_d = S_LUSE;
      S_LUSE:  state_d = S_RRD;
      S_RRD:   state_d = S_RUSE;
      S_RUSE:  state_d = S_AWR;
      S_AWR:   if (sts_i.wr_done) state_d = S_AFIN;
      S_AFIN:  state_d = S_DONE;
      S_RGN:   state_d = sts_i.in_rgn ? S_ODIVW : S_DONE;
      S_ODIVW: begin
        if (sts_i.div_done) state_d = (sts_i.cmd == CMD_FREE) ? S_FRD : S_SRD;
      end
      S_FRD:   state_d = sts_i.idx_in ? S_FID : S_DONE;
      S_FID:   state_d = sts_i.tag_zero ? S_DONE : S_FBR;
      S_FBR:   state_d = S_FBU;
      S_FBU: begin
        if (!sts_i.tag_eq || sts_i.i_zero) state_d = S_FFR;
        else state_d = S_FBR;
      end
      S_FFR:   state_d = sts_i.i_in ? S_FFU : S_FFIN;
      S_FFU:   state_d = sts_i.tag_eq ? S_FFR : S_FFIN;
      S_FFIN:  state_d = S_DONE;
      S_SRD:   state_d = sts_i.idx_in ? S_SID : S_SMUL;
      S_SID:   state_d = S_SCR;
      S_SCR:   state_d = sts_i.i_in ? S_SCU : S_SMUL;
      S_SCU:   state_d = sts_i.tag_eq ? S_SCR : S_SMUL;
      S_SMUL:  state_d = S_SFIN;
      S_SFIN:  state_d = S_DONE;
      S_DONE:  if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o      = '{op: OP_NOP, dsel: DS_NB, rsel: RS_I};
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.op = OP_SWEEP;
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_NB:   cmd_o = '{op: OP_DIV, dsel: DS_NB, rsel: RS_I};
      S_MDIV: cmd_o = '{op: OP_DIV, dsel: DS_META, rsel: RS_I};
      S_ISW:  cmd_o.op = OP_SWEEP;
      S_IFIN: cmd_o.op = OP_IFIN;
      S_AMUL: cmd_o.op = OP_UMUL;
      S_APRE: if (!sts_i.pre_fail) cmd_o = '{op: OP_DIV, dsel: DS_BSM, rsel: RS_I};
      S_RB:   cmd_o = '{op: OP_DIV, dsel: DS_RB, rsel: RS_I};
      S_M32:  cmd_o = '{op: OP_DIV, dsel: DS_M32, rsel: RS_I};
      S_ASTART: cmd_o.op = OP_ASTART;
      S_AADDR: cmd_o.op = OP_AADDR;
      S_R0:   cmd_o = '{op: OP_DIV, dsel: DS_R0, rsel: RS_I};
      S_CHK: begin
        if (sts_i.scan_ok) cmd_o.op = sts_i.askip ? OP_ADV1 : OP_WSTART;
      end
      S_WRD: begin
        cmd_o.rsel = RS_Q;
        if (!sts_i.found && !sts_i.q_in) cmd_o.op = OP_ADVW;
      end
      S_WUSE: cmd_o.op = sts_i.tag_zero ? OP_WSTEP : OP_ADVW;
      S_LRD:  cmd_o.rsel = RS_PM1;
      S_LUSE: cmd_o.op = OP_LEFT;
      S_RRD:  cmd_o.rsel = RS_Q;
      S_RUSE: cmd_o.op = OP_RIGHT;
      S_AWR:  if (!sts_i.wr_done) cmd_o.op = OP_WRID;
      S_AFIN: cmd_o.op = OP_AFIN;
      S_RGN:  if (sts_i.in_rgn) cmd_o = '{op: OP_DIV, dsel: DS_OFF, rsel: RS_I};
      S_FID:  if (!sts_i.tag_zero) cmd_o.op = OP_FID;
      S_FBU: begin
        if (!sts_i.tag_eq) cmd_o.op = OP_INC;
        else if (!sts_i.i_zero) cmd_o.op = OP_DEC;
      end
      S_FFU:  if (sts_i.tag_eq) cmd_o.op = OP_CLRI;
      S_FFIN: cmd_o.op = OP_FFIN;
      S_SID:  cmd_o.op = OP_SID;
      S_SCU:  if (sts_i.tag_eq) cmd_o.op = OP_SINC;
      S_SMUL: cmd_o.op = OP_SMUL;
      S_SFIN: cmd_o.op = OP_SFIN;
      S_DONE: if (sts_i.out_free) cmd_o.op = OP_PUSH;
      default: cmd_o.op = OP_NOP;
    endcase
  end
endmodule
`default_nettype wire

### sv/tbba_dp.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tbba_dp
// Allocator datapath: tag memory, scan pointers, residue tracking, result word.
// -----------------------------------------------------------------------------
module tbba_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tbba_pkg::tbba_cmd_t cmd_i,
  output tbba_pkg::tbba_sts_t      sts_o,
  input  wire logic [31:0]         cfg_base_i,
  input  wire logic [31:0]         cfg_bytes_i,
  input  wire logic [12:0]         cfg_block_i,
  input  wire logic [1:0]          command_i,
  input  wire logic [31:0]         request_bytes_i,
  input  wire logic [16:0]         align_bytes_i,
  input  wire logic [31:0]         address_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [31:0]              result_address_o,
  output logic [31:0]              result_bytes_o,
  output logic                     ok_o,
  output logic [10:0]              used_count_o
);
  import tbba_pkg::*;

  logic [1:0] tags [NBLK];

  // persistent state
  logic [IDXW-1:0] last_q;
  logic [CNTW-1:0] used_q;
  // item and scan registers
  cmd_e            cmd_q;
  logic [31:0]     req_q, ptr_q, a_q, aw_q, res_addr_q, res_bytes_q;
  logic [16:0]     align_q, bsm_q, rb_q, m32_q, r_q, rw_q;
  logic [CNTW-1:0] nb_q, meta_q, i_q, q_q, cnt_q, d_q;
  logic [IDXW-1:0] p_q;
  logic [23:0]     prod_q, acc_q;
  logic [12:0]     rem_q;
  logic [1:0]      id_q, left_q, rdata_q;
  logic            idx_in_q, ok_q;
  div_sel_e        dsel_q;
  logic            out_valid_q;
  logic [31:0]     out_addr_q, out_bytes_q;
  logic            out_ok_q;
  logic [CNTW-1:0] out_used_q;

  logic [12:0]     bs;
  logic [31:0]     div_a;
  logic [16:0]     div_b;
  logic            div_busy, div_done;
  logic [31:0]     div_q;
  logic [16:0]     div_r;
  logic [IDXW-1:0] rd_addr;
  logic [16:0]     off;
  logic [33:0]     need;
  logic [31:0]     rel, free_bytes;
  logic [32:0]     a_inc, aw_inc;
  logic [CNTW-1:0] last_eff, p0;
  logic [CNTW:0]   used_sum;

  function automatic logic [16:0] rstep(logic [16:0] r, logic carry, logic [16:0] bsm,
                                         logic [16:0] m32, logic [16:0] al);
    logic [18:0] t;
    t = 19'(r) + 19'(bsm) + (carry ? (19'(al) - 19'(m32)) : 19'd0);
    if (t >= 19'(al)) t = t - 19'(al);
    if (t >= 19'(al)) t = t - 19'(al);
    return t[16:0];
  endfunction

  // lowest non-free tag that differs from both neighbors
  function automatic logic [1:0] pick_tag(logic [1:0] l, logic [1:0] r);
    logic [1:0] t;
    if (l != TAG_ONE && r != TAG_ONE) t = TAG_ONE;
    else if (l != TAG_TWO && r != TAG_TWO) t = TAG_TWO;
    else t = TAG_MAX;
    return t;
  endfunction

  assign bs     = (cfg_block_i == 13'd0) ? 13'd1 : cfg_block_i;
  assign off    = (r_q == 17'd0) ? 17'd0 : align_q - r_q;
  assign need   = 34'(req_q) + 34'(off);
  assign rel    = ptr_q - cfg_base_i;
  assign a_inc  = 33'(a_q) + 33'(bs);
  assign aw_inc = 33'(aw_q) + 33'(bs);
  assign free_bytes = (32'(prod_q) > cfg_bytes_i) ? 32'd0 : cfg_bytes_i - 32'(prod_q);
  assign last_eff = (CNTW'(last_q) >= nb_q) ? nb_q - 1'b1 : CNTW'(last_q);
  assign p0       = (last_eff + 1'b1 >= nb_q) ? '0 : last_eff + 1'b1;
  assign used_sum = (CNTW + 1)'(used_q) + (CNTW + 1)'(cnt_q);

  always_comb begin
    div_a = cfg_bytes_i;
    div_b = 17'(bs);
    case (cmd_i.dsel)
      DS_NB:   div_a = cfg_bytes_i;
      DS_META: div_a = 32'((nb_q + CNTW'(TAGS_PER_BYTE - 1)) >> TPB_SHIFT) + 32'(bs) - 32'd1;
      DS_BSM: begin
        div_a = 32'(bs);
        div_b = align_q;
      end
      DS_RB: begin
        div_a = cfg_base_i;
        div_b = align_q;
      end
      DS_M32: begin
        div_a = 32'd0 - 32'(align_q);
        div_b = align_q;
      end
      DS_R0: begin
        div_a = a_q;
        div_b = align_q;
      end
      DS_OFF:  div_a = rel;
      default: div_a = cfg_bytes_i;
    endcase
  end

  tbba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == OP_DIV),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  always_comb begin
    case (cmd_i.rsel)
      RS_P:    rd_addr = p_q;
      RS_PM1:  rd_addr = p_q - 1'b1;
      RS_Q:    rd_addr = q_q[IDXW-1:0];
      default: rd_addr = i_q[IDXW-1:0];
    endcase
  end

  // tag memory
  always_ff @(posedge clk_i) begin
    rdata_q <= tags[rd_addr];
    case (cmd_i.op)
      OP_SWEEP: tags[i_q[IDXW-1:0]] <= (i_q < meta_q) ? TAG_ONE : TAG_FREE;
      OP_WRID:  tags[i_q[IDXW-1:0]] <= id_q;
      OP_CLRI:  tags[i_q[IDXW-1:0]] <= TAG_FREE;
      default: ;
    endcase
  end

  // control and allocator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      used_q      <= '0;
      meta_q      <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_PUSH) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (div_done && dsel_q == DS_META) begin
        meta_q <= (div_q > 32'(nb_q)) ? nb_q : div_q[CNTW-1:0];
        i_q    <= '0;
      end
      if (div_done && dsel_q == DS_OFF) i_q <= div_q[CNTW-1:0];
      case (cmd_i.op)
        OP_SWEEP, OP_WRID, OP_CLRI, OP_INC, OP_SINC: i_q <= i_q + 1'b1;
        OP_DEC:   i_q <= i_q - 1'b1;
        OP_RIGHT: i_q <= CNTW'(p_q);
        OP_IFIN: begin
          last_q <= (meta_q == '0) ? '0 : IDXW'(meta_q - 1'b1);
          used_q <= meta_q;
        end
        OP_AFIN: begin
          last_q <= IDXW'(q_q - 1'b1);
          used_q <= (used_sum > (CNTW + 1)'(NBLK)) ? CNTW'(NBLK) : used_sum[CNTW-1:0];
        end
        OP_FFIN: used_q <= (cnt_q > used_q) ? '0 : used_q - cnt_q;
        default: ;
      endcase
    end
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DIV) dsel_q <= cmd_i.dsel;
    if (div_done) begin
      case (dsel_q)
        DS_NB:  nb_q <= (div_q > 32'(NBLK)) ? CNTW'(NBLK) : div_q[CNTW-1:0];
        DS_BSM: bsm_q <= div_r;
        DS_RB:  rb_q <= div_r;
        DS_M32: m32_q <= div_r;
        DS_R0:  r_q <= div_r;
        DS_OFF: begin
          idx_in_q <= div_q < 32'(nb_q);
          rem_q    <= div_r[12:0];
        end
        default: ;
      endcase
    end
    case (cmd_i.op)
      OP_LOAD: begin
        cmd_q       <= cmd_e'(command_i);
        req_q       <= request_bytes_i;
        align_q     <= (align_bytes_i == 17'd0) ? 17'd1 : align_bytes_i;
        ptr_q       <= address_i;
        cnt_q       <= '0;
        res_addr_q  <= '0;
        res_bytes_q <= '0;
        ok_q        <= 1'b0;
      end
      OP_DIV:  if (cmd_i.dsel == DS_OFF) ok_q <= 1'b1;
      OP_IFIN: ok_q <= 1'b1;
      OP_UMUL: prod_q <= 24'(used_q) * 24'(bs);
      OP_ASTART: begin
        p_q    <= p0[IDXW-1:0];
        d_q    <= '0;
        prod_q <= 24'(p0) * 24'(bs);
      end
      OP_AADDR: a_q <= cfg_base_i + 32'(prod_q);
      OP_WSTART: begin
        q_q   <= CNTW'(p_q);
        aw_q  <= a_q;
        rw_q  <= r_q;
        cnt_q <= '0;
        acc_q <= '0;
      end
      OP_WSTEP: begin
        q_q   <= q_q + 1'b1;
        cnt_q <= cnt_q + 1'b1;
        acc_q <= acc_q + 24'(bs);
        aw_q  <= aw_inc[31:0];
        rw_q  <= rstep(rw_q, aw_inc[32], bsm_q, m32_q, align_q);
      end
      OP_ADV1, OP_ADVW: begin
        // a too-short free run is skipped as a whole; otherwise step one block
        if (cmd_i.op == OP_ADVW && cnt_q != '0) begin
          d_q <= d_q + cnt_q;
          if (q_q >= nb_q) begin
            p_q <= '0;
            a_q <= cfg_base_i;
            r_q <= rb_q;
          end else begin
            p_q <= q_q[IDXW-1:0];
            a_q <= aw_q;
            r_q <= rw_q;
          end
        end else begin
          d_q <= d_q + 1'b1;
          if (CNTW'(p_q) + 1'b1 >= nb_q) begin
            p_q <= '0;
            a_q <= cfg_base_i;
            r_q <= rb_q;
          end else begin
            p_q <= p_q + 1'b1;
            a_q <= a_inc[31:0];
            r_q <= rstep(r_q, a_inc[32], bsm_q, m32_q, align_q);
          end
        end
      end
      OP_LEFT:  left_q <= (p_q == '0) ? TAG_FREE : rdata_q;
      OP_RIGHT: id_q <= pick_tag(left_q, (q_q < nb_q) ? rdata_q : TAG_FREE);
      OP_AFIN: begin
        res_addr_q <= a_q + 32'(off);
        ok_q       <= 1'b1;
      end
      OP_FID: begin
        id_q  <= rdata_q;
        cnt_q <= '0;
      end
      OP_SID:  id_q <= rdata_q;
      OP_CLRI, OP_SINC: cnt_q <= cnt_q + 1'b1;
      OP_SMUL: prod_q <= 24'(cnt_q) * 24'(bs);
      OP_SFIN: res_bytes_q <= (prod_q < 24'(rem_q)) ? 32'd0 : 32'(prod_q - 24'(rem_q));
      OP_PUSH: begin
        out_addr_q  <= res_addr_q;
        out_bytes_q <= res_bytes_q;
        out_ok_q    <= ok_q;
        out_used_q  <= used_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.cmd        = cmd_q;
    sts_o.div_done   = div_done;
    sts_o.pre_fail   = (nb_q == '0) || (free_bytes < req_q);
    sts_o.scan_ok    = ((CNTW + 1)'(d_q) + 1'b1) < (CNTW + 1)'(nb_q);
    sts_o.askip      = (align_q > 17'(bs)) && ((18'(r_q) + 18'(bs)) <= 18'(align_q));
    sts_o.found      = (cnt_q != '0) && (34'(acc_q) >= need);
    sts_o.q_in       = q_q < nb_q;
    sts_o.i_in       = i_q < nb_q;
    sts_o.i_zero     = i_q == '0;
    sts_o.idx_in     = idx_in_q;
    sts_o.in_rgn     = (ptr_q >= cfg_base_i) && (rel < cfg_bytes_i);
    sts_o.tag_zero   = rdata_q == TAG_FREE;
    sts_o.tag_eq     = rdata_q == id_q;
    sts_o.wr_done    = i_q == q_q;
    sts_o.sweep_last = i_q == CNTW'(NBLK - 1);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign result_bytes_o   = out_bytes_q;
  assign ok_o             = out_ok_q;
  assign used_count_o     = out_used_q;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNTW'(NBLK))
    else $error("used block count above block limit");
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_PUSH) |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten before taken");
  a_wr_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_WRID) |-> (i_q < q_q))
    else $error("tag write outside allocated run");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DIV) |-> !div_busy)
    else $error("divider started while busy");
`endif
endmodule
`default_nettype wire

### sv/two_bit_tag_bitmap_block_allocator_core.sv
`default_nettype none
// -----------------------------------------------------------------------------
// two_bit_tag_bitmap_block_allocator_core
// Heap block allocator over one region with a 2-bit tag per block.
// -----------------------------------------------------------------------------
// Usage:
//   req_i : one word per command (init, allocate, free, size query).
//   rsp_o : one result word per command, held until rsp_o.ready.
//   cfg_i : register writes (base, region bytes, block bytes), always ready;
//           write only while no command is in flight.
// Timing: one command at a time. Every command first divides the region size
//   by the block size on a bit-serial divider. Init then sweeps all 1024 tag
//   entries. Allocate adds four setup divisions, then scans tag entries
//   through the single tag memory read port, skipping start blocks that the
//   alignment rules out, and then writes the tag of each allocated block.
//   Free and size add one division and then walk tag entries.
// Reset: the tag memory is cleared one entry a cycle, all 1024 entries, during
//   which req_i.ready stays low.
// A stalled rsp_o does not block the next command; that command finishes its
//   work and then waits for the result register to empty.
// -----------------------------------------------------------------------------
module two_bit_tag_bitmap_block_allocator_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tbba_req_if.sink   req_i,
  tbba_rsp_if.source rsp_o,
  tbba_cfg_if.sink   cfg_i
);
  import tbba_pkg::*;

  logic [31:0] base_q, bytes_q;
  logic [12:0] block_q;
  tbba_cmd_t   cmd;
  tbba_sts_t   sts;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      bytes_q <= '0;
      block_q <= 13'd16;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BASE:  base_q <= cfg_i.data;
        CFG_BYTES: bytes_q <= cfg_i.data;
        CFG_BLOCK: block_q <= cfg_i.data[12:0];
        default: ;
      endcase
    end
  end

  tbba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tbba_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_base_i       (base_q),
    .cfg_bytes_i      (bytes_q),
    .cfg_block_i      (block_q),
    .command_i        (req_i.command),
    .request_bytes_i  (req_i.request_bytes),
    .align_bytes_i    (req_i.align_bytes),
    .address_i        (req_i.address),
    .out_valid_o      (rsp_o.valid),
    .out_ready_i      (rsp_o.ready),
    .result_address_o (rsp_o.result_address),
    .result_bytes_o   (rsp_o.result_bytes),
    .ok_o             (rsp_o.ok),
    .used_count_o     (rsp_o.used_count)
  );
endmodule
`default_nettype wire
